// File: rtl/bip32_derivation_field_extract_assert.svh
// Assertion macros for the key-derivation record parser.
`ifndef BIP32_DERIVATION_FIELD_EXTRACT_ASSERT_SVH
`define BIP32_DERIVATION_FIELD_EXTRACT_ASSERT_SVH

// Check cons in the same cycle as ante.
`define BDE_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("bde assertion failed");

// Check cons in the cycle after ante.
`define BDE_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("bde assertion failed");

`endif

// File: rtl/bde_pkg.sv
// Types, constants and helpers shared by the key-derivation record parser.
`timescale 1ns / 1ps
`default_nettype none
package bde_pkg;

   localparam logic [7:0] HASH_LIMIT = 8'd128;
   localparam int         HASH_SHIFT = 5;
   localparam int         WORD_BYTES = 4;
   localparam int         JOB_IDX_W  = 6;

   typedef struct packed {
      logic [7:0]  data_byte;
      logic        record_start;
      logic        record_end;
      logic [15:0] record_length;
      logic        taproot_mode;
   } bde_req_type;

   typedef struct packed {
      logic [31:0] path_word;
      logic [3:0]  step_count;
      logic        parse_error;
      logic        last_word;
   } bde_rsp_type;

   typedef struct packed {
      logic                 bank;
      logic                 err;
      logic [JOB_IDX_W-1:0] last_idx;
      logic [3:0]           count;
   } bde_job_type;

   typedef struct packed {
      logic       err;
      logic       first;
      logic       last;
      logic [3:0] count;
   } bde_tag_type;

   function automatic logic [31:0] bde_swap32(input logic [31:0] w);
      return {w[7:0], w[15:8], w[23:16], w[31:24]};
   endfunction

endpackage
`default_nettype wire

// File: rtl/bde_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none
module bde_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 32
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output      logic [WIDTH-1:0]         rd_data_ff
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

endmodule
`default_nettype wire

// File: rtl/bde_parser.sv
// Byte-side record parser: length checks, word assembly and buffer writes.
`timescale 1ns / 1ps
`default_nettype none
module bde_parser #(
   parameter int MAX_PATH_STEPS = 10
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_valid,
   input  wire bde_pkg::bde_req_type          req_data,
   output      logic                          req_stall,
   input  wire logic                          emit_busy,
   output      logic                          wr_en,
   output      logic [$clog2(MAX_PATH_STEPS+1):0] wr_addr,
   output      logic [31:0]                   wr_data,
   output      logic                          job_valid,
   output      bde_pkg::bde_job_type          job
);
   import bde_pkg::*;

   localparam int          WIDX      = $clog2(MAX_PATH_STEPS + 1);
   localparam logic [15:0] BUF_BYTES = 16'(WORD_BYTES * (MAX_PATH_STEPS + 1));

   logic        active_ff, active_in;
   logic        err_ff, err_in;
   logic        bank_ff, bank_in;
   logic [15:0] len_ff, len_in;
   logic [15:0] skip_ff, skip_in;
   logic [15:0] dlen_ff, dlen_in;
   logic [15:0] pos_ff, pos_in;
   logic [23:0] asm_ff, asm_in;

   logic        fire, start, active_e, err_hash, err_new, err_e, over, err_nx, fail;
   logic        byte_wr;
   logic [15:0] skip_new, dlen_new, len_e, skip_e, dlen_e, p, idx, p_nx;
   logic [13:0] last_w;

   assign req_stall = emit_busy && req_data.record_end;
   assign fire      = req_valid && !req_stall;
   assign start     = req_data.record_start;

   always_comb begin
      skip_new = (16'(req_data.data_byte) << HASH_SHIFT) + 16'd1;
      err_hash = req_data.taproot_mode &&
                 ((req_data.data_byte > HASH_LIMIT) || (req_data.record_length < skip_new));
      if (!req_data.taproot_mode) begin
         dlen_new = req_data.record_length;
      end else if (err_hash) begin
         dlen_new = 16'd0;
      end else begin
         dlen_new = req_data.record_length - skip_new;
      end
      err_new = err_hash || (dlen_new > BUF_BYTES);

      active_e = start || active_ff;
      len_e    = start ? req_data.record_length : len_ff;
      skip_e   = start ? (req_data.taproot_mode ? skip_new : 16'd0) : skip_ff;
      dlen_e   = start ? dlen_new : dlen_ff;
      err_e    = start ? err_new : err_ff;
      p        = start ? 16'd0 : pos_ff;

      over    = p >= len_e;
      idx     = p - skip_e;
      byte_wr = fire && active_e && !over && !err_e && (p >= skip_e) &&
                (idx < dlen_e) && (idx < BUF_BYTES);
      err_nx  = err_e || over;
      p_nx    = (p != 16'hFFFF) ? p + 16'd1 : p;
      fail    = err_nx || (p_nx != len_e) || (dlen_e < 16'(WORD_BYTES)) ||
                (dlen_e[1:0] != 2'b00) || (dlen_e > BUF_BYTES);
      last_w  = dlen_e[15:2] - 14'd1;
   end

   assign wr_en     = byte_wr && (idx[1:0] == 2'b11);
   assign wr_addr   = {bank_ff, idx[WIDX+1:2]};
   assign wr_data   = {req_data.data_byte, asm_ff};
   assign job_valid = fire && active_e && req_data.record_end;

   always_comb begin
      job.bank     = bank_ff;
      job.err      = fail;
      job.last_idx = last_w[JOB_IDX_W-1:0];
      job.count    = last_w[3:0];
   end

   always_comb begin
      active_in = active_ff;
      err_in    = err_ff;
      len_in    = len_ff;
      skip_in   = skip_ff;
      dlen_in   = dlen_ff;
      pos_in    = pos_ff;
      asm_in    = asm_ff;
      bank_in   = bank_ff;
      if (fire && active_e) begin
         active_in = !req_data.record_end;
         err_in    = err_nx;
         len_in    = len_e;
         skip_in   = skip_e;
         dlen_in   = dlen_e;
         pos_in    = p_nx;
      end
      if (byte_wr) begin
         asm_in = {req_data.data_byte, asm_ff[23:8]};
      end
      if (job_valid) begin
         bank_in = !bank_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= 1'b0;
         err_ff    <= 1'b0;
         len_ff    <= 16'd0;
         skip_ff   <= 16'd0;
         dlen_ff   <= 16'd0;
         pos_ff    <= 16'd0;
         bank_ff   <= 1'b0;
      end else begin
         active_ff <= active_in;
         err_ff    <= err_in;
         len_ff    <= len_in;
         skip_ff   <= skip_in;
         dlen_ff   <= dlen_in;
         pos_ff    <= pos_in;
         bank_ff   <= bank_in;
      end
      asm_ff <= asm_in;
   end

endmodule
`default_nettype wire

// File: rtl/bde_emitter.sv
// Result side: reads buffered words one per cycle when not stalled; drives the result beats.
`timescale 1ns / 1ps
`default_nettype none
module bde_emitter #(
   parameter int MAX_PATH_STEPS = 10
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              job_valid,
   input  wire bde_pkg::bde_job_type              job,
   output      logic                              emit_busy,
   output      logic                              rd_en,
   output      logic [$clog2(MAX_PATH_STEPS+1):0] rd_addr,
   input  wire logic [31:0]                       rd_data,
   output      logic                              rsp_valid,
   input  wire logic                              rsp_stall,
   output      bde_pkg::bde_rsp_type              rsp_data
);
   import bde_pkg::*;

   localparam int WIDX = $clog2(MAX_PATH_STEPS + 1);

   logic            busy_ff, busy_in;
   logic            bank_ff, bank_in;
   logic            err_ff, err_in;
   logic [3:0]      count_ff, count_in;
   logic [WIDX-1:0] idx_ff, idx_in;
   logic [WIDX-1:0] last_ff, last_in;
   logic            rdv_ff, rdv_in;
   bde_tag_type     tag_ff, tag_in;
   logic            rspv_ff, rspv_in;
   bde_rsp_type     rsp_ff, rsp_in;

   logic out_load, issue, done;

   assign out_load  = !rspv_ff || !rsp_stall;
   assign issue     = busy_ff && (!rdv_ff || out_load);
   assign done      = err_ff || (idx_ff == last_ff);
   assign rd_en     = issue && !err_ff;
   assign rd_addr   = {bank_ff, idx_ff};
   assign emit_busy = busy_ff;
   assign rsp_valid = rspv_ff;
   assign rsp_data  = rsp_ff;

   always_comb begin
      busy_in  = busy_ff;
      bank_in  = bank_ff;
      err_in   = err_ff;
      count_in = count_ff;
      idx_in   = idx_ff;
      last_in  = last_ff;
      if (job_valid) begin
         busy_in  = 1'b1;
         bank_in  = job.bank;
         err_in   = job.err;
         count_in = job.err ? 4'd0 : job.count;
         idx_in   = '0;
         last_in  = job.last_idx[WIDX-1:0];
      end else if (issue) begin
         busy_in = !done;
         idx_in  = idx_ff + WIDX'(1);
      end
   end

   always_comb begin
      rdv_in = rdv_ff;
      tag_in = tag_ff;
      if (issue) begin
         rdv_in       = 1'b1;
         tag_in.err   = err_ff;
         tag_in.first = (idx_ff == '0);
         tag_in.last  = done;
         tag_in.count = count_ff;
      end else if (out_load) begin
         rdv_in = 1'b0;
      end
   end

   always_comb begin
      rspv_in = rspv_ff;
      rsp_in  = rsp_ff;
      if (out_load) begin
         rspv_in            = rdv_ff;
         rsp_in.step_count  = tag_ff.count;
         rsp_in.parse_error = tag_ff.err;
         rsp_in.last_word   = tag_ff.last;
         if (tag_ff.err) begin
            rsp_in.path_word = 32'd0;
         end else if (tag_ff.first) begin
            rsp_in.path_word = bde_swap32(rd_data);
         end else begin
            rsp_in.path_word = rd_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         rdv_ff  <= 1'b0;
         rspv_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         rdv_ff  <= rdv_in;
         rspv_ff <= rspv_in;
      end
      bank_ff  <= bank_in;
      err_ff   <= err_in;
      count_ff <= count_in;
      idx_ff   <= idx_in;
      last_ff  <= last_in;
      tag_ff   <= tag_in;
      rsp_ff   <= rsp_in;
   end

endmodule
`default_nettype wire

// File: rtl/bip32_derivation_field_extract.sv
// Top level of the key-derivation record parser.
`timescale 1ns / 1ps
`default_nettype none
`include "bip32_derivation_field_extract_assert.svh"
// Takes one record byte per beat and accepts a byte every cycle unless a
// closing beat is stalled. Derivation bytes are packed into 32-bit words in
// a two-bank word RAM, one bank per record, so a record can stream in while
// the previous one is read out. On the closing beat the record's words (or
// one error beat) follow at one result beat per cycle while rsp_stall is
// low, passing through the busy flag, the RAM read register and the result
// register. The RAM's single read port sets that rate: a closing beat is
// stalled while the previous record's words are still being read out.
// A word of the path is valid only when its record wrote it; the RAM has no reset.
module bip32_derivation_field_extract #(
   parameter int MAX_PATH_STEPS = 10
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   input  wire bde_pkg::bde_req_type req_data,
   output      logic                 req_stall,
   output      logic                 rsp_valid,
   input  wire logic                 rsp_stall,
   output      bde_pkg::bde_rsp_type rsp_data
);
   import bde_pkg::*;

   localparam int WIDX  = $clog2(MAX_PATH_STEPS + 1);
   localparam int DEPTH = 2 << WIDX;

   logic            emit_busy, job_valid, wr_en, rd_en;
   logic [WIDX:0]   wr_addr, rd_addr;
   logic [31:0]     wr_data, rd_data;
   bde_job_type     job;

   bde_parser #(.MAX_PATH_STEPS(MAX_PATH_STEPS)) u_parser (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_data  (req_data),
      .req_stall (req_stall),
      .emit_busy (emit_busy),
      .wr_en     (wr_en),
      .wr_addr   (wr_addr),
      .wr_data   (wr_data),
      .job_valid (job_valid),
      .job       (job)
   );

   bde_ram #(.WIDTH(32), .DEPTH(DEPTH)) u_ram (
      .clock      (clock),
      .wr_en      (wr_en),
      .wr_addr    (wr_addr),
      .wr_data    (wr_data),
      .rd_en      (rd_en),
      .rd_addr    (rd_addr),
      .rd_data_ff (rd_data)
   );

   bde_emitter #(.MAX_PATH_STEPS(MAX_PATH_STEPS)) u_emitter (
      .clock     (clock),
      .reset     (reset),
      .job_valid (job_valid),
      .job       (job),
      .emit_busy (emit_busy),
      .rd_en     (rd_en),
      .rd_addr   (rd_addr),
      .rd_data   (rd_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   `BDE_ASSERT_NOW(a_bank_split, clock, reset, wr_en && rd_en, wr_addr != rd_addr)
   `BDE_ASSERT_NOW(a_job_idle, clock, reset, job_valid, !emit_busy)
   `BDE_ASSERT_NEXT(a_job_taken, clock, reset, job_valid, emit_busy)
   `BDE_ASSERT_NOW(a_err_beat, clock, reset, rsp_valid && rsp_data.parse_error,
      rsp_data.path_word == 32'd0 && rsp_data.last_word && rsp_data.step_count == 4'd0)

endmodule
`default_nettype wire
